FILE: hw/rtl/qph_pkg.sv
// Shared types and constants of the quadratic probe hash table.
// Used by qph_slot_ram and quadratic_probe_hash_table_unit; depends on nothing.
`default_nettype none

package qph_pkg;

    localparam int unsigned CFG_W   = 11;
    localparam int unsigned POS_W   = 10;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned COUNT_W = 11;

    localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 11'd1021;

    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_CLEAR     = 8'b0000_0010,
        S_MOD       = 8'b0000_0100,
        S_PROBE_RD  = 8'b0000_1000,
        S_PROBE_CHK = 8'b0001_0000,
        S_SLOT_RD   = 8'b0010_0000,
        S_SLOT_CHK  = 8'b0100_0000,
        S_DONE      = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

    typedef struct packed {
        logic found;
        logic inserted;
        logic probe_fail;
    } t_flags;

endpackage

`default_nettype wire

FILE: hw/rtl/qph_modadd.sv
// Shared add-and-reduce unit: y = (a + b) reduced once by the table size.
// Serves the modulo bit steps and the probe position and step updates; no package use.
`default_nettype none

module qph_modadd #(
    parameter int unsigned SW = 11
) (
    input  wire logic [SW:0]   i_a,
    input  wire logic [SW-1:0] i_b,
    input  wire logic [SW-1:0] i_mod,
    output logic      [SW-1:0] o_y
);

    logic [SW:0] w_sum;
    logic [SW:0] w_red;

    always_comb begin
        w_sum = i_a + {1'b0, i_b};
        // operands keep the sum below twice the modulus, so one subtract suffices
        if (w_sum >= {1'b0, i_mod}) begin
            w_red = w_sum - {1'b0, i_mod};
        end else begin
            w_red = w_sum;
        end
        o_y = w_red[SW-1:0];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/qph_slot_ram.sv
// Single-port slot memory holding used mark, key and element handle per slot.
// Depends on qph_pkg for the port control struct and data width.
`default_nettype none

module qph_slot_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10,
    parameter int unsigned KW    = 32
) (
    input  wire logic                          i_clk,
    input  wire qph_pkg::t_mem_ctl             i_ctl,
    input  wire logic [AW-1:0]                 i_addr,
    input  wire logic                          i_wr_used,
    input  wire logic [KW-1:0]                 i_wr_key,
    input  wire logic [qph_pkg::DATA_W-1:0]    i_wr_elem,
    output logic                               o_rd_used,
    output logic      [KW-1:0]                 o_rd_key,
    output logic      [qph_pkg::DATA_W-1:0]    o_rd_elem
);

    localparam int unsigned WW = 1 + KW + qph_pkg::DATA_W;

    logic [WW-1:0] r_mem [DEPTH];
    logic [WW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= {i_wr_used, i_wr_key, i_wr_elem};
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_used = r_rd_data[WW-1];
    assign o_rd_key  = r_rd_data[WW-2 -: KW];
    assign o_rd_elem = r_rd_data[qph_pkg::DATA_W-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/quadratic_probe_hash_table_unit.sv
// Open-addressing hash table with quadratic probing over a single-port slot memory.
// Find and insert form key mod table_size one bit a cycle over KW = min(KEY_BITS, 32)
// key bits through the shared add-and-reduce unit, then do a memory read and then a
// compare per probe, at most table_size probes, then hand over the result once the
// output register is free. Read slot reads, checks and hands over. Clear sweeps the
// used marks one slot a cycle. After reset the same sweep runs with o_stall high.
// One transaction is in work at a time; a finished result waits in the output
// register while the next transaction is accepted.
// Depends on qph_pkg, qph_modadd and qph_slot_ram.
`default_nettype none

module quadratic_probe_hash_table_unit #(
    parameter int unsigned DEPTH    = 1024,
    parameter int unsigned KEY_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [qph_pkg::CFG_W-1:0]     i_cfg_wr_data,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [qph_pkg::MODE_W-1:0]    i_mode,
    input  wire logic [qph_pkg::DATA_W-1:0]    i_key,
    input  wire logic [qph_pkg::DATA_W-1:0]    i_element,
    input  wire logic [qph_pkg::POS_W-1:0]     i_slot_index,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [qph_pkg::POS_W-1:0]     o_position,
    output logic                               o_found,
    output logic                               o_inserted,
    output logic                               o_probe_fail,
    output logic      [qph_pkg::DATA_W-1:0]    o_element_out,
    output logic      [qph_pkg::DATA_W-1:0]    o_key_out,
    output logic      [qph_pkg::COUNT_W-1:0]   o_entry_count
);

    localparam int unsigned AW  = $clog2(DEPTH);
    localparam int unsigned SW  = $clog2(DEPTH + 1);
    localparam int unsigned KW  = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int unsigned KBW = $clog2(KW);
    localparam int unsigned PW  = qph_pkg::POS_W;
    localparam int unsigned DW  = qph_pkg::DATA_W;

    qph_pkg::t_state r_state, n_state;

    logic [qph_pkg::CFG_W-1:0] r_table_size;

    logic [qph_pkg::MODE_W-1:0] r_mode, n_mode;
    logic [KW-1:0]  r_key, n_key;
    logic [DW-1:0]  r_elem, n_elem;
    logic [PW-1:0]  r_idx, n_idx;

    logic [SW-1:0]  r_size, n_size;
    logic [SW-1:0]  r_rem, n_rem;
    logic [SW-1:0]  r_home, n_home;
    logic [SW-1:0]  r_pos, n_pos;
    logic [SW-1:0]  r_pnext, n_pnext;
    logic [SW-1:0]  r_step, n_step;
    logic [SW-1:0]  r_probe, n_probe;
    logic [SW-1:0]  r_count, n_count;
    logic [KBW-1:0] r_bit, n_bit;
    logic [AW-1:0]  r_sweep, n_sweep;
    logic           r_clr_report, n_clr_report;

    logic [PW-1:0]     r_res_pos, n_res_pos;
    qph_pkg::t_flags   r_res_flags, n_res_flags;
    logic [DW-1:0]     r_res_elem, n_res_elem;
    logic [DW-1:0]     r_res_key, n_res_key;

    logic                         r_out_valid, n_out_valid;
    logic [PW-1:0]                r_out_pos, n_out_pos;
    qph_pkg::t_flags              r_out_flags, n_out_flags;
    logic [DW-1:0]                r_out_elem, n_out_elem;
    logic [DW-1:0]                r_out_key, n_out_key;
    logic [qph_pkg::COUNT_W-1:0]  r_out_count, n_out_count;

    logic [SW:0]    w_ua;
    logic [SW-1:0]  w_ub;
    logic [SW-1:0]  w_uy;

    qph_pkg::t_mem_ctl w_mem_ctl;
    logic [AW-1:0]  w_mem_addr;
    logic           w_wr_used;
    logic [KW-1:0]  w_wr_key;
    logic [DW-1:0]  w_wr_elem;
    logic           w_rd_used;
    logic [KW-1:0]  w_rd_key;
    logic [DW-1:0]  w_rd_elem;

    logic [SW-1:0]  w_eff_size;
    logic           w_idx_oob;
    logic [SW-1:0]  w_probe_inc;

    qph_modadd #(
        .SW (SW)
    ) u_modadd (
        .i_a   (w_ua),
        .i_b   (w_ub),
        .i_mod (r_size),
        .o_y   (w_uy)
    );

    qph_slot_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .KW    (KW)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_ctl     (w_mem_ctl),
        .i_addr    (w_mem_addr),
        .i_wr_used (w_wr_used),
        .i_wr_key  (w_wr_key),
        .i_wr_elem (w_wr_elem),
        .o_rd_used (w_rd_used),
        .o_rd_key  (w_rd_key),
        .o_rd_elem (w_rd_elem)
    );

    // clamp the programmed size into 1..DEPTH
    always_comb begin
        if (r_table_size == '0) begin
            w_eff_size = SW'(1);
        end else if (32'(r_table_size) > 32'(DEPTH)) begin
            w_eff_size = SW'(DEPTH);
        end else begin
            w_eff_size = SW'(r_table_size);
        end
    end

    assign w_idx_oob   = 32'(r_idx) >= 32'(DEPTH);
    assign w_probe_inc = r_probe + SW'(1);

    assign o_stall = (r_state != qph_pkg::S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_key        = r_key;
        n_elem       = r_elem;
        n_idx        = r_idx;
        n_size       = r_size;
        n_rem        = r_rem;
        n_home       = r_home;
        n_pos        = r_pos;
        n_pnext      = r_pnext;
        n_step       = r_step;
        n_probe      = r_probe;
        n_count      = r_count;
        n_bit        = r_bit;
        n_sweep      = r_sweep;
        n_clr_report = r_clr_report;
        n_res_pos    = r_res_pos;
        n_res_flags  = r_res_flags;
        n_res_elem   = r_res_elem;
        n_res_key    = r_res_key;
        n_out_valid  = r_out_valid;
        n_out_pos    = r_out_pos;
        n_out_flags  = r_out_flags;
        n_out_elem   = r_out_elem;
        n_out_key    = r_out_key;
        n_out_count  = r_out_count;

        w_ua       = '0;
        w_ub       = '0;
        w_mem_ctl  = '0;
        w_mem_addr = AW'(r_pos);
        w_wr_used  = 1'b0;
        w_wr_key   = r_key;
        w_wr_elem  = r_elem;

        // drop the output transaction once taken
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            qph_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_mode = i_mode;
                    n_key  = i_key[KW-1:0];
                    n_elem = i_element;
                    n_idx  = i_slot_index;
                    n_size = w_eff_size;
                    case (i_mode)
                        qph_pkg::MODE_CLEAR: begin
                            n_sweep      = '0;
                            n_clr_report = 1'b1;
                            n_state      = qph_pkg::S_CLEAR;
                        end
                        qph_pkg::MODE_READ: begin
                            n_state = qph_pkg::S_SLOT_RD;
                        end
                        default: begin
                            n_rem   = '0;
                            n_bit   = KBW'(KW - 1);
                            n_state = qph_pkg::S_MOD;
                        end
                    endcase
                end
            end
            qph_pkg::S_CLEAR: begin
                w_mem_ctl.wr_en = 1'b1;
                w_mem_addr      = r_sweep;
                w_wr_used       = 1'b0;
                if (r_sweep == AW'(DEPTH - 1)) begin
                    n_count = '0;
                    if (r_clr_report) begin
                        n_res_pos   = '0;
                        n_res_flags = '0;
                        n_res_elem  = '0;
                        n_res_key   = '0;
                        n_state     = qph_pkg::S_DONE;
                    end else begin
                        n_state = qph_pkg::S_IDLE;
                    end
                end else begin
                    n_sweep = r_sweep + AW'(1);
                end
            end
            qph_pkg::S_MOD: begin
                // shift in one key bit, most significant first
                w_ua  = {r_rem, r_key[r_bit]};
                w_ub  = '0;
                n_rem = w_uy;
                if (r_bit == '0) begin
                    n_home  = w_uy;
                    n_pos   = w_uy;
                    n_step  = (r_size == SW'(1)) ? '0 : SW'(1);
                    n_probe = '0;
                    n_state = qph_pkg::S_PROBE_RD;
                end else begin
                    n_bit = r_bit - KBW'(1);
                end
            end
            qph_pkg::S_PROBE_RD: begin
                w_mem_ctl.rd_en = 1'b1;
                w_mem_addr      = AW'(r_pos);
                w_ua            = {1'b0, r_pos};
                w_ub            = r_step;
                n_pnext         = w_uy;
                n_state         = qph_pkg::S_PROBE_CHK;
            end
            qph_pkg::S_PROBE_CHK: begin
                w_ua = {1'b0, r_step};
                w_ub = SW'(2);
                if (!w_rd_used || (w_rd_key == r_key)) begin
                    n_res_pos   = PW'(r_pos);
                    n_res_flags = '0;
                    n_res_elem  = '0;
                    n_res_key   = '0;
                    if (w_rd_used) begin
                        n_res_flags.found = 1'b1;
                        n_res_elem        = w_rd_elem;
                        n_res_key         = DW'(w_rd_key);
                    end else if (r_mode == qph_pkg::MODE_INSERT) begin
                        w_mem_ctl.wr_en      = 1'b1;
                        w_mem_addr           = AW'(r_pos);
                        w_wr_used            = 1'b1;
                        n_count              = r_count + SW'(1);
                        n_res_flags.inserted = 1'b1;
                        n_res_elem           = r_elem;
                        n_res_key            = DW'(r_key);
                    end
                    n_state = qph_pkg::S_DONE;
                end else if (w_probe_inc == r_size) begin
                    n_res_pos              = PW'(r_home);
                    n_res_flags            = '0;
                    n_res_flags.probe_fail = 1'b1;
                    n_res_elem             = '0;
                    n_res_key              = '0;
                    n_state                = qph_pkg::S_DONE;
                end else begin
                    n_probe = w_probe_inc;
                    n_pos   = r_pnext;
                    n_step  = w_uy;
                    n_state = qph_pkg::S_PROBE_RD;
                end
            end
            qph_pkg::S_SLOT_RD: begin
                if (w_idx_oob) begin
                    n_res_pos   = r_idx;
                    n_res_flags = '0;
                    n_res_elem  = '0;
                    n_res_key   = '0;
                    n_state     = qph_pkg::S_DONE;
                end else begin
                    w_mem_ctl.rd_en = 1'b1;
                    w_mem_addr      = AW'(r_idx);
                    n_state         = qph_pkg::S_SLOT_CHK;
                end
            end
            qph_pkg::S_SLOT_CHK: begin
                n_res_pos   = r_idx;
                n_res_flags = '0;
                if (w_rd_used) begin
                    n_res_flags.found = 1'b1;
                    n_res_elem        = w_rd_elem;
                    n_res_key         = DW'(w_rd_key);
                end else begin
                    n_res_elem = '0;
                    n_res_key  = '0;
                end
                n_state = qph_pkg::S_DONE;
            end
            qph_pkg::S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = r_res_pos;
                    n_out_flags = r_res_flags;
                    n_out_elem  = r_res_elem;
                    n_out_key   = r_res_key;
                    n_out_count = qph_pkg::COUNT_W'(r_count);
                    n_state     = qph_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = qph_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= qph_pkg::S_CLEAR;
            r_table_size <= qph_pkg::TABLE_SIZE_RESET;
            r_count      <= '0;
            r_sweep      <= '0;
            r_clr_report <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_sweep      <= n_sweep;
            r_clr_report <= n_clr_report;
            r_out_valid  <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_table_size <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_key       <= n_key;
        r_elem      <= n_elem;
        r_idx       <= n_idx;
        r_size      <= n_size;
        r_rem       <= n_rem;
        r_home      <= n_home;
        r_pos       <= n_pos;
        r_pnext     <= n_pnext;
        r_step      <= n_step;
        r_probe     <= n_probe;
        r_bit       <= n_bit;
        r_res_pos   <= n_res_pos;
        r_res_flags <= n_res_flags;
        r_res_elem  <= n_res_elem;
        r_res_key   <= n_res_key;
        r_out_pos   <= n_out_pos;
        r_out_flags <= n_out_flags;
        r_out_elem  <= n_out_elem;
        r_out_key   <= n_out_key;
        r_out_count <= n_out_count;
    end

    assign o_valid       = r_out_valid;
    assign o_position    = r_out_pos;
    assign o_found       = r_out_flags.found;
    assign o_inserted    = r_out_flags.inserted;
    assign o_probe_fail  = r_out_flags.probe_fail;
    assign o_element_out = r_out_elem;
    assign o_key_out     = r_out_key;
    assign o_entry_count = r_out_count;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SW'(DEPTH))
        else $error("occupied count exceeds table depth");

    a_write_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_ctl.wr_en |-> ((r_state == qph_pkg::S_CLEAR) ||
            ((r_state == qph_pkg::S_PROBE_CHK) && (r_mode == qph_pkg::MODE_INSERT))))
        else $error("slot memory written outside clear or insert");

    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qph_pkg::S_PROBE_RD) |-> ((r_pos < r_size) && (r_probe < r_size)))
        else $error("probe position or count out of range");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == qph_pkg::S_PROBE_CHK) && w_mem_ctl.wr_en)
            |=> (r_count == ($past(r_count) + SW'(1))))
        else $error("insert did not advance occupied count");
`endif

endmodule

`default_nettype wire
